// ===== design/pcle_pkg.sv =====
// shared constants, codes and types for the positional circular list engine
package pcle_pkg;

  localparam int CAPACITY = 32;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_LAST = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH   = 3'd4;
  localparam logic [OP_W-1:0] OP_READOUT  = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LINK,
    S_VICT,
    S_RESP
  } ctrl_state_t;

  // one read address shared by both stores, one write port each
  typedef struct packed {
    logic [SLOT_W-1:0]       rd_addr;
    logic                    lnk_we;
    logic [SLOT_W-1:0]       lnk_waddr;
    logic [SLOT_W-1:0]       lnk_wdata;
    logic                    val_we;
    logic [SLOT_W-1:0]       val_waddr;
    logic signed [VAL_W-1:0] val_wdata;
  } ram_req_t;

endpackage

// ===== design/pcle_ram.sv =====
// generic single-write, single-read ram with registered read data
module pcle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pcle_ctrl.sv =====
// list sequencer: head, tail, count, free mask and the chain walk over the stores
module pcle_ctrl
  import pcle_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  input  logic [SLOT_W-1:0]       lnk_q,
  input  logic signed [VAL_W-1:0] val_q,
  output ram_req_t                ram_req,
  input  logic                    can_push,
  output logic                    push,
  output out_item_t               push_data
);

  ctrl_state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]       head_r, head_nxt;
  logic [SLOT_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CAPACITY-1:0]     free_r, free_nxt;
  logic [OP_W-1:0]         op_r, op_nxt;
  logic [CNT_W-1:0]        tgt_r, tgt_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [SLOT_W-1:0]       dslot_r, dslot_nxt;
  logic [SLOT_W-1:0]       new_r, new_nxt;
  logic [SLOT_W-1:0]       prev_r, prev_nxt;
  logic [SLOT_W-1:0]       victim_r, victim_nxt;
  logic                    head_set_r, head_set_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [ST_W-1:0]         st_r, st_nxt;
  logic [POS_W-1:0]        fp_r, fp_nxt;

  logic              full, empty, single;
  logic [POS_W-1:0]  count_ext, count_p1, ipos, dpos;
  logic              is_err, go_ins, go_del, go_scan;
  logic [ST_W-1:0]   err_st;
  logic [SLOT_W-1:0] free_slot;
  logic              at_tgt, hit;

  function automatic logic [SLOT_W-1:0] lowest_set(input logic [CAPACITY-1:0] m);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign single    = (count_r == CNT_W'(1));
  assign count_ext = POS_W'(count_r);
  assign count_p1  = count_ext + POS_W'(1);
  assign free_slot = lowest_set(free_r);
  assign at_tgt    = (idx_r == tgt_r);
  assign hit       = (val_q == key_r);

  // decode of the request at the input
  always_comb begin
    is_err  = 1'b0;
    err_st  = ST_OK;
    go_ins  = 1'b0;
    go_del  = 1'b0;
    go_scan = 1'b0;
    ipos    = in_data.position;
    dpos    = in_data.position;
    case (in_data.operation)
      OP_INSERT: begin
        if (full) begin
          is_err = 1'b1;
          err_st = ST_FULL;
        end else if (in_data.position == '0 || in_data.position > count_p1) begin
          is_err = 1'b1;
          err_st = ST_BAD_POS;
        end else begin
          go_ins = 1'b1;
        end
      end
      OP_APPEND: begin
        ipos = count_p1;
        if (full) begin
          is_err = 1'b1;
          err_st = ST_FULL;
        end else begin
          go_ins = 1'b1;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          is_err = 1'b1;
          err_st = ST_EMPTY;
        end else if (in_data.position == '0 || in_data.position > count_ext) begin
          is_err = 1'b1;
          err_st = ST_BAD_POS;
        end else begin
          go_del = 1'b1;
        end
      end
      OP_DEL_LAST: begin
        dpos = count_ext;
        if (empty) begin
          is_err = 1'b1;
          err_st = ST_EMPTY;
        end else begin
          go_del = 1'b1;
        end
      end
      OP_SEARCH, OP_READOUT: begin
        if (empty) begin
          is_err = 1'b1;
          err_st = ST_EMPTY;
        end else begin
          go_scan = 1'b1;
        end
      end
      default: begin
        is_err = 1'b1;
        err_st = ST_BAD_POS;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (is_err) begin
            state_nxt = S_RESP;
          end else if (go_ins) begin
            if (empty) begin
              state_nxt = S_RESP;
            end else if (ipos == POS_W'(1)) begin
              state_nxt = S_LINK;
            end else begin
              state_nxt = S_WALK;
            end
          end else if (go_del) begin
            if (single) begin
              state_nxt = S_RESP;
            end else if (dpos == POS_W'(1)) begin
              state_nxt = S_VICT;
            end else begin
              state_nxt = S_WALK;
            end
          end else if (go_scan) begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        case (op_r)
          OP_INSERT, OP_APPEND: begin
            if (at_tgt) begin
              state_nxt = S_LINK;
            end
          end
          OP_DELETE, OP_DEL_LAST: begin
            if (at_tgt) begin
              state_nxt = S_VICT;
            end
          end
          OP_SEARCH: begin
            if (hit || at_tgt) begin
              state_nxt = S_RESP;
            end
          end
          OP_READOUT: begin
            if (can_push && at_tgt) begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LINK:  state_nxt = S_RESP;
      S_VICT:  state_nxt = S_RESP;
      S_RESP: begin
        if (can_push) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    free_nxt     = free_r;
    op_nxt       = op_r;
    tgt_nxt      = tgt_r;
    idx_nxt      = idx_r;
    dslot_nxt    = dslot_r;
    new_nxt      = new_r;
    prev_nxt     = prev_r;
    victim_nxt   = victim_r;
    head_set_nxt = head_set_r;
    key_nxt      = key_r;
    st_nxt       = st_r;
    fp_nxt       = fp_r;
    ram_req           = '0;
    ram_req.rd_addr   = dslot_r;
    push              = 1'b0;
    push_data.status         = st_r;
    push_data.found_position = fp_r;
    push_data.out_value      = '0;
    push_data.last           = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_data.operation;
          key_nxt         = in_data.item_value;
          st_nxt          = is_err ? err_st : ST_OK;
          fp_nxt          = '0;
          idx_nxt         = CNT_W'(1);
          dslot_nxt       = head_r;
          head_set_nxt    = 1'b0;
          ram_req.rd_addr = head_r;
          if (go_ins) begin
            new_nxt             = free_slot;
            free_nxt[free_slot] = 1'b0;
            ram_req.val_we      = 1'b1;
            ram_req.val_waddr   = free_slot;
            ram_req.val_wdata   = in_data.item_value;
            tgt_nxt             = CNT_W'(ipos - POS_W'(1));
            if (empty) begin
              // first entry links to itself
              ram_req.lnk_we    = 1'b1;
              ram_req.lnk_waddr = free_slot;
              ram_req.lnk_wdata = free_slot;
              head_nxt          = free_slot;
              tail_nxt          = free_slot;
              count_nxt         = CNT_W'(1);
            end else if (ipos == POS_W'(1)) begin
              ram_req.lnk_we    = 1'b1;
              ram_req.lnk_waddr = free_slot;
              ram_req.lnk_wdata = head_r;
              prev_nxt          = tail_r;
              head_set_nxt      = 1'b1;
            end
          end else if (go_del) begin
            tgt_nxt = CNT_W'(dpos - POS_W'(1));
            if (single) begin
              free_nxt[head_r] = 1'b1;
              head_nxt         = '0;
              tail_nxt         = '0;
              count_nxt        = '0;
            end else if (dpos == POS_W'(1)) begin
              // head removal: tail acts as predecessor
              prev_nxt   = tail_r;
              victim_nxt = head_r;
            end
          end else if (go_scan) begin
            tgt_nxt = count_r;
          end
        end
      end
      S_WALK: begin
        case (op_r)
          OP_INSERT, OP_APPEND: begin
            if (at_tgt) begin
              ram_req.lnk_we    = 1'b1;
              ram_req.lnk_waddr = new_r;
              ram_req.lnk_wdata = lnk_q;
              prev_nxt          = dslot_r;
            end else begin
              ram_req.rd_addr = lnk_q;
              dslot_nxt       = lnk_q;
              idx_nxt         = idx_r + CNT_W'(1);
            end
          end
          OP_DELETE, OP_DEL_LAST: begin
            ram_req.rd_addr = lnk_q;
            if (at_tgt) begin
              prev_nxt   = dslot_r;
              victim_nxt = lnk_q;
            end else begin
              dslot_nxt = lnk_q;
              idx_nxt   = idx_r + CNT_W'(1);
            end
          end
          OP_SEARCH: begin
            if (hit) begin
              st_nxt = ST_OK;
              fp_nxt = POS_W'(idx_r);
            end else if (at_tgt) begin
              st_nxt = ST_NOT_FOUND;
            end else begin
              ram_req.rd_addr = lnk_q;
              dslot_nxt       = lnk_q;
              idx_nxt         = idx_r + CNT_W'(1);
            end
          end
          OP_READOUT: begin
            push_data.status         = ST_OK;
            push_data.found_position = '0;
            push_data.out_value      = val_q;
            push_data.last           = at_tgt;
            if (can_push) begin
              push = 1'b1;
              if (!at_tgt) begin
                ram_req.rd_addr = lnk_q;
                dslot_nxt       = lnk_q;
                idx_nxt         = idx_r + CNT_W'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_LINK: begin
        ram_req.lnk_we    = 1'b1;
        ram_req.lnk_waddr = prev_r;
        ram_req.lnk_wdata = new_r;
        count_nxt         = count_r + CNT_W'(1);
        if (head_set_r) begin
          head_nxt = new_r;
        end else if (prev_r == tail_r) begin
          tail_nxt = new_r;
        end
      end
      S_VICT: begin
        // lnk_q holds the successor of the victim
        ram_req.lnk_we     = 1'b1;
        ram_req.lnk_waddr  = prev_r;
        ram_req.lnk_wdata  = lnk_q;
        free_nxt[victim_r] = 1'b1;
        count_nxt          = count_r - CNT_W'(1);
        if (victim_r == tail_r) begin
          tail_nxt = prev_r;
        end
        if (victim_r == head_r) begin
          head_nxt = lnk_q;
        end
      end
      S_RESP: begin
        push = can_push;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      free_r  <= '1;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tgt_r      <= tgt_nxt;
    idx_r      <= idx_nxt;
    dslot_r    <= dslot_nxt;
    new_r      <= new_nxt;
    prev_r     <= prev_nxt;
    victim_r   <= victim_nxt;
    head_set_r <= head_set_nxt;
    key_r      <= key_nxt;
    st_r       <= st_nxt;
    fp_r       <= fp_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_free_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(~free_r) == int'(count_r))
    else $error("free mask disagrees with entry count");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty list with nonzero head or tail");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("result pushed into a full output register");
`endif

endmodule

// ===== design/positional_circular_list_engine.sv =====
// top level: list sequencer, value and link stores, result output register
// error results and head or empty-list edits skip the chain walk; every other request
//   first walks the chain from the head toward its position
// throughput: one request at a time; read out streams one entry per cycle when not stalled
// the chain walk (one link-store read per cycle) sets how long a request takes
// reset: synchronous active-low rst_n empties the list and drops any waiting result;
//   the stores hold no reset and need no clearing pass
module positional_circular_list_engine
  import pcle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // ram traffic from the sequencer
  ram_req_t                ram_req;
  logic [SLOT_W-1:0]       lnk_q;
  logic signed [VAL_W-1:0] val_q;

  // result handoff into the output register
  logic      can_push;
  logic      push;
  out_item_t push_data;

  logic      out_valid_r;
  out_item_t out_data_r;

  // sequencer owns head, tail, count and free mask and walks the chain
  pcle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .lnk_q     (lnk_q),
    .val_q     (val_q),
    .ram_req   (ram_req),
    .can_push  (can_push),
    .push      (push),
    .push_data (push_data)
  );

  // next-slot links of the circular chain
  pcle_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_req.lnk_we),
    .waddr (ram_req.lnk_waddr),
    .wdata (ram_req.lnk_wdata),
    .raddr (ram_req.rd_addr),
    .rdata (lnk_q)
  );

  // entry values, read at the same slot as the link
  pcle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_req.val_we),
    .waddr (ram_req.val_waddr),
    .wdata (ram_req.val_wdata),
    .raddr (ram_req.rd_addr),
    .rdata (val_q)
  );

  // register takes a new result when empty or when the current one leaves
  assign can_push = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload held while stalled
  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
